// ----- design/polynomial_dewarp_mapper_assert.svh -----
// Assertion helpers for the dewarp mapper.
`ifndef POLYNOMIAL_DEWARP_MAPPER_ASSERT_SVH
`define POLYNOMIAL_DEWARP_MAPPER_ASSERT_SVH

// same-cycle implication
`define DWM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dwm: assertion failed");

// next-cycle implication
`define DWM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dwm: assertion failed");

`endif

// ----- design/dwm_pkg.sv -----
package dwm_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 24;

    localparam int COEF_W  = 32;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int N_COEF  = 7;
    localparam int N_PAIRS = 7;
    localparam int CENTER_HALF = 16;

    // signed operand widths; products are sized to be exact
    localparam int D_W   = COORD_BITS + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int CU_W  = 3 * D_W;
    localparam int LO_W  = CU_W / 2;
    localparam int HI_W  = CU_W - LO_W;
    localparam int ACC_W = CU_W + COEF_W + 2;

    localparam int OUT_W = 18;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
    localparam int X_UNIT_PAIR = 0;
    localparam int Y_UNIT_PAIR = 4;

    // pipeline stage positions
    localparam int ST_D     = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_CU    = 2;
    localparam int ST_PROD  = 3;
    localparam int ST_SUM1  = 4;
    localparam int ST_SUM2  = 5;
    localparam int ST_TOT   = 6;
    localparam int ST_OUT   = 7;
    localparam int N_STAGES = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_PAIR_0,
        REG_COEF_PAIR_1,
        REG_COEF_PAIR_2,
        REG_COEF_PAIR_3,
        REG_COEF_PAIR_4,
        REG_COEF_PAIR_5,
        REG_COEF_PAIR_6,
        REG_WARP_CENTER
    } reg_idx_t;

    typedef struct packed {
        logic [N_STAGES-1:0] en;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [SQ_W-1:0] dx2;
        logic signed [SQ_W-1:0] dy2;
        logic signed [SQ_W-1:0] dxy;
        logic signed [CU_W-1:0] dx2y;
        logic signed [CU_W-1:0] dxy2;
    } mono_t;

    typedef logic [N_COEF-1:0][COEF_W-1:0] axis_coef_t;

endpackage

// ----- design/polynomial_dewarp_mapper.sv -----
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+----------------------------
// input    | in  | in_valid / in_ready   | dest_x, dest_y
// result   | out | out_valid / out_ready | src_x, src_y, clipped
// config   | in  | cfg_we                | cfg_index, cfg_data
//
// One request per cycle while out_ready does not stall it; it passes the register stages
// (difference, squares, cubes, coefficient products, three adder levels and a
// saturation stage). The widest multiplier is 32 x 34 (coefficient by square).
// Reset clears the stage valid bits and loads the identity map, center zero.
// A stage holds while the one after it is full and stalled; empty stages
// keep filling, so the input side stalls only when all eight stages are full.
`include "polynomial_dewarp_mapper_assert.svh"

module polynomial_dewarp_mapper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dwm_pkg::COORD_BITS-1:0]    dest_x,
    input  logic [dwm_pkg::COORD_BITS-1:0]    dest_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [dwm_pkg::OUT_W-1:0]  src_x,
    output logic signed [dwm_pkg::OUT_W-1:0]  src_y,
    output logic                              clipped,
    input  logic                              cfg_we,
    input  logic [dwm_pkg::IDX_W-1:0]         cfg_index,
    input  logic [dwm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int N_STAGES = dwm_pkg::N_STAGES;
    localparam int ST_D     = dwm_pkg::ST_D;
    localparam int ST_CU    = dwm_pkg::ST_CU;
    localparam int ST_PROD  = dwm_pkg::ST_PROD;
    localparam int ST_TOT   = dwm_pkg::ST_TOT;
    localparam int ST_OUT   = dwm_pkg::ST_OUT;

    logic [N_STAGES-1:0]  vld_reg;
    logic [N_STAGES-1:0]  vld_next;
    logic [N_STAGES-1:0]  en;
    dwm_pkg::pipe_ctrl_t  ctrl;

    dwm_pkg::axis_coef_t              coef_x;
    dwm_pkg::axis_coef_t              coef_y;
    logic [dwm_pkg::COORD_BITS-1:0]   center_x;
    logic [dwm_pkg::COORD_BITS-1:0]   center_y;
    dwm_pkg::mono_t                   mono;
    logic                             clip_x;
    logic                             clip_y;
    logic                             x_sat;
    logic                             y_sat;

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        en[N_STAGES-1] = !vld_reg[N_STAGES-1] || out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < N_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.en = en;

    dwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_x    (coef_x),
        .coef_y    (coef_y),
        .center_x  (center_x),
        .center_y  (center_y)
    );

    dwm_mono u_mono (
        .clk      (clk),
        .ctrl     (ctrl),
        .dest_x   (dest_x),
        .dest_y   (dest_y),
        .center_x (center_x),
        .center_y (center_y),
        .mono     (mono)
    );

    dwm_axis u_axis_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .mono   (mono),
        .coef   (coef_x),
        .center (center_x),
        .coord  (src_x),
        .clip   (clip_x)
    );

    dwm_axis u_axis_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .mono   (mono),
        .coef   (coef_y),
        .center (center_y),
        .coord  (src_y),
        .clip   (clip_y)
    );

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ST_OUT];
    assign clipped   = clip_x || clip_y;

    assign x_sat = (src_x == dwm_pkg::OUT_MAX) || (src_x == dwm_pkg::OUT_MIN);
    assign y_sat = (src_y == dwm_pkg::OUT_MAX) || (src_y == dwm_pkg::OUT_MIN);

    `DWM_ASSERT_NXT(a_in_enters, clk, rst_n, in_valid && in_ready, vld_reg[ST_D])
    `DWM_ASSERT_NXT(a_stage_holds, clk, rst_n, vld_reg[ST_TOT] && !en[ST_TOT], vld_reg[ST_TOT])
    `DWM_ASSERT_NXT(a_stage_moves, clk, rst_n, vld_reg[ST_CU] && en[ST_PROD], vld_reg[ST_PROD])
    `DWM_ASSERT_IMP(a_full_blocks, clk, rst_n, (&vld_reg) && !out_ready, !in_ready)
    `DWM_ASSERT_IMP(a_clip_sat, clk, rst_n, out_valid && clipped, x_sat || y_sat)

endmodule

// ----- design/dwm_cfg.sv -----
module dwm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dwm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [dwm_pkg::CFG_W-1:0]     cfg_data,
    output dwm_pkg::axis_coef_t           coef_x,
    output dwm_pkg::axis_coef_t           coef_y,
    output logic [dwm_pkg::COORD_BITS-1:0] center_x,
    output logic [dwm_pkg::COORD_BITS-1:0] center_y
);

    localparam int CFG_W   = dwm_pkg::CFG_W;
    localparam int COEF_W  = dwm_pkg::COEF_W;
    localparam int N_COEF  = dwm_pkg::N_COEF;
    localparam int HALF    = dwm_pkg::CENTER_HALF;
    localparam int COORD_BITS = dwm_pkg::COORD_BITS;
    localparam logic [CFG_W-1:0] PAIR_ONE = CFG_W'(dwm_pkg::COEF_ONE);

    logic [dwm_pkg::N_PAIRS-1:0][CFG_W-1:0] pair_reg;
    logic [2*HALF-1:0]                      center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dwm_pkg::N_PAIRS; i++)
            begin
                pair_reg[i] <= (i == dwm_pkg::X_UNIT_PAIR || i == dwm_pkg::Y_UNIT_PAIR)
                               ? PAIR_ONE : '0;
            end
            center_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (dwm_pkg::reg_idx_t'(cfg_index))
                dwm_pkg::REG_COEF_PAIR_0,
                dwm_pkg::REG_COEF_PAIR_1,
                dwm_pkg::REG_COEF_PAIR_2,
                dwm_pkg::REG_COEF_PAIR_3,
                dwm_pkg::REG_COEF_PAIR_4,
                dwm_pkg::REG_COEF_PAIR_5,
                dwm_pkg::REG_COEF_PAIR_6:
                begin
                    pair_reg[cfg_index] <= cfg_data;
                end
                dwm_pkg::REG_WARP_CENTER:
                begin
                    center_reg <= cfg_data[2*HALF-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // coefficient k sits in pair k/2, low half for even k
    for (genvar g = 0; g < N_COEF; g++)
    begin : g_coef
        localparam int KX = g;
        localparam int KY = g + N_COEF;
        assign coef_x[g] = (KX % 2 == 1) ? pair_reg[KX/2][2*COEF_W-1:COEF_W]
                                         : pair_reg[KX/2][COEF_W-1:0];
        assign coef_y[g] = (KY % 2 == 1) ? pair_reg[KY/2][2*COEF_W-1:COEF_W]
                                         : pair_reg[KY/2][COEF_W-1:0];
    end

    assign center_x = COORD_BITS'(center_reg[HALF-1:0]);
    assign center_y = COORD_BITS'(center_reg[2*HALF-1:HALF]);

endmodule

// ----- design/dwm_mono.sv -----
module dwm_mono (
    input  logic                           clk,
    input  dwm_pkg::pipe_ctrl_t            ctrl,
    input  logic [dwm_pkg::COORD_BITS-1:0] dest_x,
    input  logic [dwm_pkg::COORD_BITS-1:0] dest_y,
    input  logic [dwm_pkg::COORD_BITS-1:0] center_x,
    input  logic [dwm_pkg::COORD_BITS-1:0] center_y,
    output dwm_pkg::mono_t                 mono
);

    localparam int D_W  = dwm_pkg::D_W;
    localparam int SQ_W = dwm_pkg::SQ_W;

    logic signed [D_W-1:0]  dx_reg;
    logic signed [D_W-1:0]  dy_reg;
    logic signed [D_W-1:0]  sq_dx_reg;
    logic signed [D_W-1:0]  sq_dy_reg;
    logic signed [SQ_W-1:0] sq_dx2_reg;
    logic signed [SQ_W-1:0] sq_dy2_reg;
    logic signed [SQ_W-1:0] sq_dxy_reg;
    dwm_pkg::mono_t         mono_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[dwm_pkg::ST_D])
        begin
            dx_reg <= $signed({1'b0, dest_x}) - $signed({1'b0, center_x});
            dy_reg <= $signed({1'b0, dest_y}) - $signed({1'b0, center_y});
        end
        if (ctrl.en[dwm_pkg::ST_SQ])
        begin
            sq_dx_reg  <= dx_reg;
            sq_dy_reg  <= dy_reg;
            sq_dx2_reg <= dx_reg * dx_reg;
            sq_dy2_reg <= dy_reg * dy_reg;
            sq_dxy_reg <= dx_reg * dy_reg;
        end
        if (ctrl.en[dwm_pkg::ST_CU])
        begin
            mono_reg.dx   <= sq_dx_reg;
            mono_reg.dy   <= sq_dy_reg;
            mono_reg.dx2  <= sq_dx2_reg;
            mono_reg.dy2  <= sq_dy2_reg;
            mono_reg.dxy  <= sq_dxy_reg;
            mono_reg.dx2y <= sq_dx2_reg * sq_dy_reg;
            mono_reg.dxy2 <= sq_dxy_reg * sq_dy_reg;
        end
    end

    assign mono = mono_reg;

endmodule

// ----- design/dwm_axis.sv -----
module dwm_axis (
    input  logic                                 clk,
    input  dwm_pkg::pipe_ctrl_t                  ctrl,
    input  dwm_pkg::mono_t                       mono,
    input  dwm_pkg::axis_coef_t                  coef,
    input  logic [dwm_pkg::COORD_BITS-1:0]       center,
    output logic signed [dwm_pkg::OUT_W-1:0]     coord,
    output logic                                 clip
);

    localparam int COEF_W = dwm_pkg::COEF_W;
    localparam int D_W    = dwm_pkg::D_W;
    localparam int SQ_W   = dwm_pkg::SQ_W;
    localparam int CU_W   = dwm_pkg::CU_W;
    localparam int LO_W   = dwm_pkg::LO_W;
    localparam int HI_W   = dwm_pkg::HI_W;
    localparam int ACC_W  = dwm_pkg::ACC_W;
    localparam int OUT_W  = dwm_pkg::OUT_W;
    localparam int FRAC_BITS = dwm_pkg::FRAC_BITS;
    localparam int TOP_W  = ACC_W - FRAC_BITS - OUT_W + 1;

    logic signed [COEF_W+D_W-1:0]    p0_reg;
    logic signed [COEF_W+D_W-1:0]    p1_reg;
    logic signed [COEF_W+SQ_W-1:0]   p2_reg;
    logic signed [COEF_W+SQ_W-1:0]   p3_reg;
    logic signed [COEF_W+SQ_W-1:0]   p4_reg;
    logic signed [COEF_W+LO_W:0]     l5_reg;
    logic signed [COEF_W+HI_W-1:0]   h5_reg;
    logic signed [COEF_W+LO_W:0]     l6_reg;
    logic signed [COEF_W+HI_W-1:0]   h6_reg;
    logic signed [ACC_W-1:0]         sa_reg;
    logic signed [ACC_W-1:0]         sb_reg;
    logic signed [ACC_W-1:0]         q5_reg;
    logic signed [ACC_W-1:0]         q6_reg;
    logic signed [ACC_W-1:0]         t1_reg;
    logic signed [ACC_W-1:0]         t2_reg;
    logic signed [ACC_W-1:0]         tot_reg;
    logic signed [OUT_W-1:0]         coord_reg;
    logic                            clip_reg;

    logic signed [ACC_W-1:0] base;
    logic [TOP_W-1:0]        top_bits;
    logic                    fits;

    assign base = ACC_W'({center, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (ctrl.en[dwm_pkg::ST_PROD])
        begin
            p0_reg <= $signed(coef[0]) * $signed(mono.dx);
            p1_reg <= $signed(coef[1]) * $signed(mono.dy);
            p2_reg <= $signed(coef[2]) * $signed(mono.dx2);
            p3_reg <= $signed(coef[3]) * $signed(mono.dy2);
            p4_reg <= $signed(coef[4]) * $signed(mono.dxy);
            // cubic terms split into an unsigned low part and a signed high part
            l5_reg <= $signed(coef[5]) * $signed({1'b0, mono.dx2y[LO_W-1:0]});
            h5_reg <= $signed(coef[5]) * $signed(mono.dx2y[CU_W-1:LO_W]);
            l6_reg <= $signed(coef[6]) * $signed({1'b0, mono.dxy2[LO_W-1:0]});
            h6_reg <= $signed(coef[6]) * $signed(mono.dxy2[CU_W-1:LO_W]);
        end
        if (ctrl.en[dwm_pkg::ST_SUM1])
        begin
            sa_reg <= base + ACC_W'(p0_reg) + ACC_W'(p1_reg);
            sb_reg <= ACC_W'(p2_reg) + ACC_W'(p3_reg) + ACC_W'(p4_reg);
            q5_reg <= (ACC_W'(h5_reg) <<< LO_W) + ACC_W'(l5_reg);
            q6_reg <= (ACC_W'(h6_reg) <<< LO_W) + ACC_W'(l6_reg);
        end
        if (ctrl.en[dwm_pkg::ST_SUM2])
        begin
            t1_reg <= sa_reg + sb_reg;
            t2_reg <= q5_reg + q6_reg;
        end
        if (ctrl.en[dwm_pkg::ST_TOT])
        begin
            tot_reg <= t1_reg + t2_reg;
        end
        if (ctrl.en[dwm_pkg::ST_OUT])
        begin
            coord_reg <= fits ? $signed(tot_reg[FRAC_BITS +: OUT_W])
                              : (tot_reg[ACC_W-1] ? dwm_pkg::OUT_MIN : dwm_pkg::OUT_MAX);
            clip_reg  <= !fits;
        end
    end

    // floor is the arithmetic shift; it fits when the bits above the
    // output field all match its sign
    assign top_bits = tot_reg[ACC_W-1 -: TOP_W];
    assign fits     = (&top_bits) || !(|top_bits);

    assign coord = coord_reg;
    assign clip  = clip_reg;

endmodule
